@@ hw/rtl/cnv_pkg.sv @@
// Package for the CIDR network validator: types, character codes and helpers.
package cnv_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [9:0] V4_OCTET_MAX  = 10'd255;
  localparam logic [2:0] V4_DIGITS_MAX = 3'd3;
  localparam logic [2:0] V4_COUNT_SAT  = 3'd7;
  localparam logic [2:0] V4_COUNT_LAST = 3'd3;
  localparam logic [2:0] V6_LEN_MAX    = 3'd4;
  localparam logic [3:0] V6_COUNT_SAT  = 4'd15;
  localparam logic [3:0] V6_FULL       = 4'd8;
  localparam logic [3:0] V6_SHORT_MAX  = 4'd7;
  localparam logic [7:0] PFX_RUN_MAX   = 8'd128;
  localparam logic [7:0] PFX_V4_MAX    = 8'd32;
  localparam logic [7:0] PFX_SAT       = 8'd255;

  // Parser state carried from one character to the next.
  typedef struct packed {
    logic       in_prefix;
    logic       address_seen;
    logic       saw_colon;
    logic       v4_ok;
    logic [2:0] v4_digit_count;
    logic [9:0] v4_octet_value;
    logic [2:0] v4_octet_count;
    logic       v6_ok;
    logic [2:0] v6_group_len;
    logic [3:0] v6_group_count;
    logic       v6_double_seen;
    logic       prev_colon;
    logic       v6_after_double;
    logic [7:0] prefix_value;
    logic       prefix_digits_seen;
    logic       prefix_ok;
  } cnv_state_t;

  localparam cnv_state_t STATE_RESET = '{
    in_prefix:          1'b0,
    address_seen:       1'b0,
    saw_colon:          1'b0,
    v4_ok:              1'b1,
    v4_digit_count:     3'd0,
    v4_octet_value:     10'd0,
    v4_octet_count:     3'd0,
    v6_ok:              1'b1,
    v6_group_len:       3'd0,
    v6_group_count:     4'd0,
    v6_double_seen:     1'b0,
    prev_colon:         1'b0,
    v6_after_double:    1'b0,
    prefix_value:       8'd0,
    prefix_digits_seen: 1'b0,
    prefix_ok:          1'b1
  };

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

endpackage

@@ hw/rtl/cidr_network_validator.sv @@
// Top level of the CIDR network validator: input register, parser state, result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   in      | sink      | in_valid_i / in_stall_o | ch_i[7:0], last_i, end_only_i
//   out     | source    | out_valid_o/out_stall_i | valid_res_o
//
// One character per cycle sustained while no string end is held back by a full result slot;
// the verdict for the transaction that carries last passes through the input register, which
// holds the character, and then the result register, which captures the verdict.
// Reset clears the valid flags and returns the parser state to its start values.
// A stalled output only backs up the input when the held character ends a string;
// other characters keep draining into the parser state.
module cidr_network_validator
  import cnv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  input  logic       end_only_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       valid_res_o
);

  // Input register stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_ch_q;
  logic       s1_last_q;
  logic       s1_end_only_q;

  // Parser state
  cnv_state_t state_q, state_d, state_step;

  logic in_accept;
  logic s1_adv;
  logic out_ready;
  logic verdict;

  // Advance the held character unless it ends a string and the result slot is full.
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_ready);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept ? 1'b1 : (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ch_q       <= ch_i;
      s1_last_q     <= last_i;
      s1_end_only_q <= end_only_i;
    end
  end

  cnv_step u_step (
    .state_i    (state_q),
    .ch_i       (s1_ch_q),
    .end_only_i (s1_end_only_q),
    .state_o    (state_step),
    .verdict_o  (verdict)
  );

  // Hold the state unless a character advances; restart after each verdict.
  always_comb begin
    state_d = state_q;
    if (s1_adv) begin
      state_d = s1_last_q ? STATE_RESET : state_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  cnv_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv && s1_last_q),
    .verdict_i   (verdict),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .valid_res_o (valid_res_o)
  );

  // A string end that advances always leaves a verdict waiting.
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> out_valid_o)
    else $error("string end did not produce a result");

  // The parser restarts from its start values after every verdict.
  a_state_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (state_q == STATE_RESET))
    else $error("parser state not restarted after verdict");

  // Backpressure only comes from a held string end facing a full result slot.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_last_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked string end");

endmodule

@@ hw/rtl/cnv_step.sv @@
// Per-character state update and end-of-string verdict for the validator.
module cnv_step
  import cnv_pkg::*;
(
  input  cnv_state_t state_i,
  input  logic [7:0] ch_i,
  input  logic       end_only_i,
  output cnv_state_t state_o,
  output logic       verdict_o
);

  cnv_state_t  n;
  logic [3:0]  digit;
  logic [11:0] pfx_t;
  logic [3:0]  groups;
  logic        g_ok;
  logic        v4_fin_ok;
  logic        ok;

  assign digit = ch_i[3:0] - 4'd0;  // low nibble of '0'..'9'
  assign pfx_t = 12'(state_i.prefix_value) * 12'd10 + 12'(digit);

  always_comb begin
    n = state_i;
    if (!end_only_i) begin
      if (state_i.in_prefix) begin
        if (!is_dec(ch_i)) begin
          n.prefix_ok = 1'b0;
        end else begin
          n.prefix_digits_seen = 1'b1;
          if (pfx_t > 12'(PFX_RUN_MAX)) n.prefix_ok = 1'b0;
          n.prefix_value = (pfx_t > 12'(PFX_SAT)) ? PFX_SAT : pfx_t[7:0];
        end
      end else if (ch_i == CH_SLASH) begin
        n.in_prefix = 1'b1;
      end else begin
        n.address_seen = 1'b1;
        // IPv4 side
        if (is_dec(ch_i)) begin
          if (state_i.v4_digit_count >= V4_DIGITS_MAX) begin
            n.v4_ok = 1'b0;
          end else begin
            n.v4_digit_count = state_i.v4_digit_count + 3'd1;
            n.v4_octet_value = state_i.v4_octet_value * 10'd10 + 10'(digit);
          end
        end else if (ch_i == CH_DOT) begin
          if (state_i.v4_digit_count == 3'd0 || state_i.v4_octet_value > V4_OCTET_MAX)
            n.v4_ok = 1'b0;
          if (state_i.v4_octet_count < V4_COUNT_SAT)
            n.v4_octet_count = state_i.v4_octet_count + 3'd1;
          n.v4_digit_count = 3'd0;
          n.v4_octet_value = 10'd0;
        end else begin
          n.v4_ok = 1'b0;
        end
        // IPv6 side
        if (ch_i == CH_COLON) begin
          n.saw_colon = 1'b1;
          if (state_i.prev_colon) begin
            if (state_i.v6_double_seen) n.v6_ok = 1'b0;
            n.v6_double_seen  = 1'b1;
            n.v6_after_double = 1'b1;
          end else begin
            if (state_i.v6_group_len != 3'd0 && state_i.v6_group_count < V6_COUNT_SAT)
              n.v6_group_count = state_i.v6_group_count + 4'd1;
            n.v6_group_len    = 3'd0;
            n.v6_after_double = 1'b0;
          end
          n.prev_colon = 1'b1;
        end else if (is_hex(ch_i)) begin
          // single leading colon
          if (state_i.prev_colon && !state_i.v6_double_seen && state_i.v6_group_count == 4'd0)
            n.v6_ok = 1'b0;
          if (state_i.v6_group_len >= V6_LEN_MAX) n.v6_ok = 1'b0;
          else n.v6_group_len = state_i.v6_group_len + 3'd1;
          n.prev_colon      = 1'b0;
          n.v6_after_double = 1'b0;
        end else begin
          n.v6_ok           = 1'b0;
          n.prev_colon      = 1'b0;
          n.v6_after_double = 1'b0;
        end
      end
    end
  end

  // Verdict on the updated state; only used when the character ends the string.
  always_comb begin
    ok = n.address_seen;
    if (n.in_prefix) begin
      if (!n.prefix_digits_seen || !n.prefix_ok) ok = 1'b0;
      if (!n.saw_colon && n.prefix_value > PFX_V4_MAX) ok = 1'b0;
    end
    groups = n.v6_group_count;
    if (n.v6_group_len != 3'd0 && groups < V6_COUNT_SAT) groups = groups + 4'd1;
    g_ok = n.v6_ok;
    if (n.prev_colon && !n.v6_after_double) g_ok = 1'b0;  // single trailing colon
    if (n.v6_double_seen) begin
      if (groups > V6_SHORT_MAX) g_ok = 1'b0;
    end else begin
      if (groups != V6_FULL) g_ok = 1'b0;
    end
    v4_fin_ok = n.v4_ok && (n.v4_digit_count != 3'd0) && (n.v4_octet_value <= V4_OCTET_MAX)
                && (n.v4_octet_count == V4_COUNT_LAST);
    verdict_o = n.saw_colon ? (ok && g_ok) : (ok && v4_fin_ok);
  end

  assign state_o = n;

endmodule

@@ hw/rtl/cnv_out.sv @@
// Result register holding one verdict until the consumer takes it.
module cnv_out
  import cnv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic verdict_i,
  output logic ready_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic valid_res_o
);

  logic out_valid_q, out_valid_d;
  logic res_q;

  assign ready_o     = !out_valid_q || !out_stall_i;
  assign out_valid_d = load_i ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= verdict_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;

endmodule
